FILE: design/i2da_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_pkg: shared types and constants for the decimal ASCII converter
// Job record passed from the front end to the digit engine, character codes
// and the reciprocal used for exact division by ten.
// ----------------------------------------------------------------------------
package i2da_pkg;

    localparam int unsigned WORD_W          = 32;
    localparam int unsigned MAX_DIGITS      = 10;
    localparam int unsigned DIGIT_IDX_W     = $clog2(MAX_DIGITS);
    localparam int unsigned DIGIT_CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int unsigned CHAR_CNT_W      = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
    localparam logic [WORD_W-1:0] RECIP_TEN   = 32'hCCCCCCCD;
    localparam int unsigned       RECIP_SHIFT = 35;

    typedef struct packed {
        logic [WORD_W-1:0] mag;
        logic              neg;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [WORD_W-1:0] div_ten(input logic [WORD_W-1:0] x);
        logic [2*WORD_W-1:0] prod;
        begin
            prod = x * RECIP_TEN;
            div_ten = {{(RECIP_SHIFT - WORD_W){1'b0}}, prod[2*WORD_W-1:RECIP_SHIFT]};
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/i2da_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_front: input stage
// Accepts items, decides the sign and forms the unsigned magnitude, and holds
// the classified job until the queue takes it.
// ----------------------------------------------------------------------------
module i2da_front
    import i2da_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [WORD_W-1:0] value_word,
    input  wire logic              signed_mode,
    input  wire logic              queue_full,
    output logic                   job_valid,
    output job_t                   job
);

    logic job_valid_reg;
    logic job_valid_next;
    job_t job_reg;
    job_t job_next;
    logic accept;
    logic neg;

    assign neg    = signed_mode & value_word[WORD_W-1];
    assign full   = job_valid_reg & queue_full;
    assign accept = push & ~full;

    always_comb
    begin
        job_next.neg   = neg;
        job_next.mag   = neg ? (~value_word + {{(WORD_W-1){1'b0}}, 1'b1}) : value_word;
        job_valid_next = job_valid_reg;
        if (job_valid_reg && !queue_full)
        begin
            job_valid_next = 1'b0;
        end
        if (accept)
        begin
            job_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule
`default_nettype wire

FILE: design/i2da_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_queue: job queue
// Short first-in first-out queue of classified jobs between the front end and
// the digit engine.
// ----------------------------------------------------------------------------
module i2da_queue
    import i2da_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire job_t    wr_job,
    input  wire logic    rd_en,
    output job_t         rd_job,
    output queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en & ~status.full;
    assign do_rd = rd_en & ~status.empty;
    assign rd_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule
`default_nettype wire

FILE: design/i2da_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_back: digit engine and character output
// Divides the magnitude by ten once a cycle, stores the remainders, then sends
// the sign and the digits most significant first through an output register.
// ----------------------------------------------------------------------------
module i2da_back
    import i2da_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire job_t             job,
    input  wire logic             job_avail,
    output logic                  job_take,
    input  wire logic             pop,
    output logic                  empty,
    output logic [7:0]            char_code,
    output logic                  last_char,
    output logic [CHAR_CNT_W-1:0] char_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t                  state_reg;
    logic [WORD_W-1:0]       prev_reg;
    logic [WORD_W-1:0]       quot_reg;
    logic                    neg_reg;
    logic [DIGIT_CNT_W-1:0]  ndig_reg;
    logic [DIGIT_IDX_W-1:0]  emit_idx_reg;
    logic [3:0]              digit_reg [MAX_DIGITS];
    logic                    out_valid_reg;
    logic [7:0]              out_char_reg;
    logic                    out_last_reg;
    logic [CHAR_CNT_W-1:0]   out_count_reg;

    logic                    out_free;
    logic [WORD_W-1:0]       quot_ten;
    logic [WORD_W-1:0]       rem_full;
    logic [3:0]              rem_digit;
    logic [3:0]              emit_digit;
    logic [CHAR_CNT_W-1:0]   total_chars;

    assign out_free   = ~out_valid_reg | pop;
    assign job_take   = (state_reg == ST_IDLE) & job_avail;
    // remainder of prev / 10, with quot already holding the quotient
    assign quot_ten   = {quot_reg[WORD_W-4:0], 3'b000} + {quot_reg[WORD_W-2:0], 1'b0};
    assign rem_full   = prev_reg - quot_ten;
    assign rem_digit  = rem_full[3:0];
    assign emit_digit = digit_reg[emit_idx_reg];
    assign total_chars = CHAR_CNT_W'(ndig_reg) + {{(CHAR_CNT_W-1){1'b0}}, neg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            ndig_reg      <= '0;
            emit_idx_reg  <= '0;
            prev_reg      <= '0;
            quot_reg      <= '0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // drop the character once taken
                    if (pop)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (job_avail)
                    begin
                        prev_reg  <= job.mag;
                        quot_reg  <= div_ten(job.mag);
                        neg_reg   <= job.neg;
                        ndig_reg  <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (pop)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    ndig_reg <= ndig_reg + 1'b1;
                    if (quot_reg == '0)
                    begin
                        emit_idx_reg <= DIGIT_IDX_W'(ndig_reg);
                        state_reg    <= neg_reg ? ST_SIGN : ST_DIGITS;
                    end
                    else
                    begin
                        prev_reg <= quot_reg;
                        quot_reg <= div_ten(quot_reg);
                    end
                end
                ST_SIGN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= CHAR_MINUS;
                        out_last_reg  <= 1'b0;
                        out_count_reg <= '0;
                        state_reg     <= ST_DIGITS;
                    end
                end
                ST_DIGITS:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= CHAR_ZERO + {4'h0, emit_digit};
                        if (emit_idx_reg == '0)
                        begin
                            out_last_reg  <= 1'b1;
                            out_count_reg <= total_chars;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            out_last_reg  <= 1'b0;
                            out_count_reg <= '0;
                            emit_idx_reg  <= emit_idx_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (pop)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // digit store, least significant first
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIVIDE)
        begin
            digit_reg[DIGIT_IDX_W'(ndig_reg)] <= rem_digit;
        end
    end

    assign empty      = ~out_valid_reg;
    assign char_code  = out_char_reg;
    assign last_char  = out_last_reg;
    assign char_count = out_count_reg;

endmodule
`default_nettype wire

FILE: design/integer_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii: 32-bit integer to decimal ASCII converter
// Turns a signed or unsigned 32-bit word into its decimal characters, most
// significant first, one character per result item.
//
//   channel   handshake          fields
//   input     push / full        value_word[31:0], signed_mode
//   result    empty / pop        char_code[7:0], last_char, char_count[3:0]
//
// An item passes through the front stage, the job queue, the divide-by-ten unit,
// which finds the digits least significant first, and the output register,
// which sends the sign, if any, and then the digits. The digit engine takes its
// next job only after it has loaded the last character of the current one.
// Reset is asynchronous and empties every stage. A stalled pop holds the
// current character; the digit engine waits and loses nothing.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii
    import i2da_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [31:0]      value_word,
    input  wire logic             signed_mode,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            char_code,
    output logic                  last_char,
    output logic [3:0]            char_count
);

    logic          front_valid;
    job_t          front_job;
    job_t          queue_job;
    queue_status_t queue_status;
    logic          back_take;

    i2da_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .value_word  (value_word),
        .signed_mode (signed_mode),
        .queue_full  (queue_status.full),
        .job_valid   (front_valid),
        .job         (front_job)
    );

    i2da_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (front_valid),
        .wr_job (front_job),
        .rd_en  (back_take),
        .rd_job (queue_job),
        .status (queue_status)
    );

    i2da_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (queue_job),
        .job_avail  (~queue_status.empty),
        .job_take   (back_take),
        .pop        (pop),
        .empty      (empty),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_count (char_count)
    );

`ifndef ASSERT_OFF
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_char) |-> (char_count != 4'd0 && char_count <= 4'd11))
        else $error("final character carries a bad count");

    a_count_zero_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_char) |-> (char_count == 4'd0))
        else $error("count set on a character that is not final");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (char_code == CHAR_MINUS ||
                    (char_code >= CHAR_ZERO && char_code <= CHAR_NINE)))
        else $error("character is neither a digit nor a minus sign");

    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && char_code == CHAR_MINUS) |-> !last_char)
        else $error("minus sign given as the final character");

    a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        back_take |-> !queue_status.empty)
        else $error("digit engine took a job from an empty queue");
`endif

endmodule
`default_nettype wire
